// ----- hdl/nau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit package
// Shared widths, operation and function codes, and the records that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package nau_pkg;

    localparam int DATA_W            = 32;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 8;

    // Reciprocal of 100 for 32-bit unsigned operands: q = (m * MAGIC) >> SHIFT.
    localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int          DIV100_SHIFT = 37;
    localparam int          DIV100_PROD_W = 62;

    typedef enum logic {
        OP_ACTIVATE = 1'b0,
        OP_DERIVE   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_SIGMOID = 3'd0,
        KIND_TANH    = 3'd1,
        KIND_RELU    = 3'd2,
        KIND_LEAKY   = 3'd3,
        KIND_LINEAR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic       opcode;
        logic [2:0] kind;
        logic       neg;
    } ctl_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     saturated;
    } res_t;

endpackage

// ----- hdl/nau_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit input channel
// Valid/ready channel that carries one operand with its opcode and kind.
// ----------------------------------------------------------------------------
interface nau_item_if;

    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [2:0]                       function_kind;
    logic signed [nau_pkg::DATA_W-1:0] operand_value;

    modport source (
        output valid,
        output opcode,
        output function_kind,
        output operand_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  function_kind,
        input  operand_value,
        output ready
    );

endinterface

// ----- hdl/nau_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit result channel
// Valid/ready channel that carries one result with its saturation flag.
// ----------------------------------------------------------------------------
interface nau_result_if;

    logic                             valid;
    logic                             ready;
    logic signed [nau_pkg::DATA_W-1:0] result_value;
    logic                             saturated;

    modport source (
        output valid,
        output result_value,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_value,
        input  saturated,
        output ready
    );

endinterface

// ----- hdl/nau_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit stage one
// Clamps the operand, scales its magnitude to a table position and forms the
// derivative product of the sigmoid or tanh.
// ----------------------------------------------------------------------------
module nau_prep #(
    parameter int  TABLE_ENTRIES = nau_pkg::TABLE_ENTRIES_DEF,
    parameter int  FRACTION_BITS = nau_pkg::FRACTION_BITS_DEF,
    localparam int ENT_W         = $clog2(TABLE_ENTRIES + 1),
    localparam int MAG_W         = FRACTION_BITS + 6,
    localparam int POS_W         = MAG_W + ENT_W - 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              opcode,
    input  logic [2:0]                        function_kind,
    input  logic signed [nau_pkg::DATA_W-1:0] operand_value,
    output nau_pkg::ctl_t                     ctl,
    output logic signed [nau_pkg::DATA_W-1:0] value,
    output logic [POS_W-1:0]                  pos,
    output logic signed [63:0]                prod
);

    localparam int SCALE_W = MAG_W + ENT_W;
    localparam logic signed [31:0] ONE      = 32'sd1 <<< FRACTION_BITS;
    localparam logic signed [31:0] SIG_LIM  = 32'sd50 <<< FRACTION_BITS;
    localparam logic signed [31:0] TANH_LIM = 32'sd20 <<< FRACTION_BITS;

    nau_pkg::ctl_t              ctl_reg;
    nau_pkg::ctl_t              ctl_next;
    logic signed [31:0]         value_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic signed [63:0]         prod_reg;
    logic signed [63:0]         prod_next;

    logic signed [31:0]         lim;
    logic signed [31:0]         clamped;
    logic [MAG_W-1:0]           mag;
    logic [SCALE_W-1:0]         scaled;
    logic signed [33:0]         mul_a;
    logic signed [33:0]         mul_b;
    logic signed [67:0]         mul_full;

    always_comb
    begin
        lim = (function_kind == nau_pkg::KIND_SIGMOID) ? SIG_LIM : TANH_LIM;
        if (operand_value > lim)
        begin
            clamped = lim;
        end
        else if (operand_value < -lim)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = operand_value;
        end
        mag    = MAG_W'((clamped < 0) ? -clamped : clamped);
        scaled = SCALE_W'(mag) * SCALE_W'(TABLE_ENTRIES);
        if (function_kind == nau_pkg::KIND_SIGMOID)
        begin
            pos_next = POS_W'(scaled >> 4);
        end
        else
        begin
            pos_next = POS_W'(scaled >> 3);
        end

        mul_a = 34'(operand_value);
        if (function_kind == nau_pkg::KIND_SIGMOID)
        begin
            mul_b = 34'(ONE) - mul_a;
        end
        else
        begin
            mul_b = mul_a;
        end
        mul_full  = mul_a * mul_b;
        prod_next = mul_full[63:0];

        ctl_next.valid  = load;
        ctl_next.opcode = opcode;
        ctl_next.kind   = function_kind;
        ctl_next.neg    = operand_value < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= operand_value;
        pos_reg   <= pos_next;
        prod_reg  <= prod_next;
    end

    assign ctl   = ctl_reg;
    assign value = value_reg;
    assign pos   = pos_reg;
    assign prod  = prod_reg;

endmodule

// ----- hdl/nau_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit stage two
// Reads the two tanh table entries around the position, truncates the
// derivative product and starts the leaky division of the operand by 100.
// ----------------------------------------------------------------------------
module nau_lookup #(
    parameter int  TABLE_ENTRIES = nau_pkg::TABLE_ENTRIES_DEF,
    parameter int  FRACTION_BITS = nau_pkg::FRACTION_BITS_DEF,
    localparam int ENT_W         = $clog2(TABLE_ENTRIES + 1),
    localparam int MAG_W         = FRACTION_BITS + 6,
    localparam int POS_W         = MAG_W + ENT_W - 3,
    localparam int TW            = FRACTION_BITS + 1,
    localparam int TRUNC_W       = 64 - FRACTION_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nau_pkg::ctl_t                        ctl_in,
    input  logic signed [nau_pkg::DATA_W-1:0]    value_in,
    input  logic [POS_W-1:0]                     pos_in,
    input  logic signed [63:0]                   prod_in,
    output nau_pkg::ctl_t                        ctl,
    output logic signed [nau_pkg::DATA_W-1:0]    value,
    output logic [TW-1:0]                        lo,
    output logic [TW-1:0]                        hi,
    output logic [FRACTION_BITS-1:0]             frac,
    output logic signed [TRUNC_W-1:0]            trunc,
    output logic [nau_pkg::DIV100_PROD_W-1:0]    quot_prod
);

    localparam int       TAB_BITS  = (TABLE_ENTRIES + 1) * TW;
    localparam int       IDX_W     = POS_W - FRACTION_BITS;
    localparam int       QP_W      = nau_pkg::DIV100_PROD_W;
    localparam logic [63:0] Q32_ONE  = 64'd1 << 32;
    localparam logic [63:0] TAB_STEP = (64'd1 << 36) / TABLE_ENTRIES;
    localparam logic signed [63:0] ROUND_BIAS = (64'sd1 <<< FRACTION_BITS) - 64'sd1;

    // Shift-and-subtract quotient, evaluated only while the table is built.
    function automatic logic [63:0] table_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry k holds tanh(8k/TABLE_ENTRIES), built from powers of exp(-16/TABLE_ENTRIES).
    function automatic logic [TAB_BITS-1:0] build_tanh_table(input logic [63:0] step);
        logic [TAB_BITS-1:0] tab;
        logic [63:0]         term;
        logic [63:0]         r;
        logic [63:0]         e;
        logic [63:0]         den;
        logic [63:0]         num;
        logic signed [63:0]  sum;
        tab  = '0;
        term = Q32_ONE;
        sum  = Q32_ONE;
        e    = Q32_ONE;
        for (int n = 1; n < 64; n++)
        begin
            if (term != 64'd0)
            begin
                term = table_quotient((term * step) >> 32, 64'(n));
                if (n[0])
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        r = sum;
        if (r > Q32_ONE)
        begin
            r = Q32_ONE;
        end
        for (int k = 0; k <= TABLE_ENTRIES; k++)
        begin
            den = Q32_ONE + e;
            num = ((Q32_ONE - e) << FRACTION_BITS) + (den >> 1);
            tab[k * TW +: TW] = TW'(table_quotient(num, den));
            e = (e * r) >> 32;
        end
        return tab;
    endfunction

    localparam logic [TAB_BITS-1:0] TANH_TAB = build_tanh_table(TAB_STEP);

    nau_pkg::ctl_t               ctl_reg;
    logic signed [31:0]          value_reg;
    logic [TW-1:0]               lo_reg;
    logic [TW-1:0]               lo_next;
    logic [TW-1:0]               hi_reg;
    logic [TW-1:0]               hi_next;
    logic [FRACTION_BITS-1:0]    frac_reg;
    logic signed [TRUNC_W-1:0]   trunc_reg;
    logic signed [TRUNC_W-1:0]   trunc_next;
    logic [QP_W-1:0]             quot_prod_reg;
    logic [QP_W-1:0]             quot_prod_next;

    logic [IDX_W-1:0]            idx_full;
    logic                        at_end;
    logic [ENT_W-1:0]            idx;
    logic [ENT_W-1:0]            idx_up;
    logic signed [63:0]          biased;
    logic [31:0]                 abs_value;

    always_comb
    begin
        idx_full = pos_in[POS_W-1:FRACTION_BITS];
        at_end   = idx_full >= IDX_W'(TABLE_ENTRIES);
        idx      = ENT_W'(idx_full);
        idx_up   = idx + 1'b1;
        if (at_end)
        begin
            lo_next = TANH_TAB[TABLE_ENTRIES * TW +: TW];
            hi_next = TANH_TAB[TABLE_ENTRIES * TW +: TW];
        end
        else
        begin
            lo_next = TANH_TAB[idx * TW +: TW];
            hi_next = TANH_TAB[idx_up * TW +: TW];
        end

        // Truncation toward zero of the product shifted down by the fraction.
        biased     = prod_in + ((prod_in < 0) ? ROUND_BIAS : 64'sd0);
        trunc_next = biased[63:FRACTION_BITS];

        abs_value      = (value_in < 0) ? 32'(-value_in) : 32'(value_in);
        quot_prod_next = QP_W'(64'(abs_value) * 64'(nau_pkg::DIV100_MAGIC));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_in;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        frac_reg      <= pos_in[FRACTION_BITS-1:0];
        trunc_reg     <= trunc_next;
        quot_prod_reg <= quot_prod_next;
    end

    assign ctl       = ctl_reg;
    assign value     = value_reg;
    assign lo        = lo_reg;
    assign hi        = hi_reg;
    assign frac      = frac_reg;
    assign trunc     = trunc_reg;
    assign quot_prod = quot_prod_reg;

endmodule

// ----- hdl/nau_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit stage three
// Multiplies the table slope by the fraction, resolves the simple functions
// and the saturated derivatives, then forms the final result.
// ----------------------------------------------------------------------------
module nau_finish #(
    parameter int  FRACTION_BITS = nau_pkg::FRACTION_BITS_DEF,
    localparam int TW            = FRACTION_BITS + 1,
    localparam int TRUNC_W       = 64 - FRACTION_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nau_pkg::ctl_t                        ctl_in,
    input  logic signed [nau_pkg::DATA_W-1:0]    value_in,
    input  logic [TW-1:0]                        lo_in,
    input  logic [TW-1:0]                        hi_in,
    input  logic [FRACTION_BITS-1:0]             frac_in,
    input  logic signed [TRUNC_W-1:0]            trunc_in,
    input  logic [nau_pkg::DIV100_PROD_W-1:0]    quot_prod_in,
    output nau_pkg::res_t                        res
);

    localparam int DV_W     = TRUNC_W + 1;
    localparam int INTERP_W = TW + FRACTION_BITS;
    localparam int Q_W      = nau_pkg::DIV100_PROD_W - nau_pkg::DIV100_SHIFT;
    localparam int SUM_W    = FRACTION_BITS + 2;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
    localparam logic signed [31:0] LEAK_SLOPE = ((32'sd1 <<< FRACTION_BITS) + 32'sd50) / 32'sd100;
    localparam logic signed [DV_W-1:0] MAX32 = DV_W'(32'sh7FFFFFFF);
    localparam logic signed [DV_W-1:0] MIN32 = DV_W'(-33'sh80000000);

    nau_pkg::ctl_t              ctl_reg;
    logic signed [31:0]         simple_reg;
    logic signed [31:0]         simple_next;
    logic                       sat_reg;
    logic                       sat_next;
    logic [TW-1:0]              lo_reg;
    logic [INTERP_W-1:0]        interp_reg;
    logic [INTERP_W-1:0]        interp_next;

    logic [TW-1:0]              diff;
    logic signed [DV_W-1:0]     deriv;
    logic signed [31:0]         deriv_sat;
    logic                       deriv_flag;
    logic [Q_W-1:0]             quot;
    logic [TW-1:0]              tval;
    logic [SUM_W-1:0]           sig_sum;
    logic [TW-1:0]              sig_half;
    logic signed [31:0]         sig_res;
    logic signed [31:0]         tanh_res;
    logic signed [31:0]         final_value;

    always_comb
    begin
        diff        = (hi_in > lo_in) ? (hi_in - lo_in) : '0;
        interp_next = INTERP_W'(diff) * INTERP_W'(frac_in);

        if (ctl_in.kind == nau_pkg::KIND_TANH)
        begin
            deriv = DV_W'(ONE) - DV_W'(trunc_in);
        end
        else
        begin
            deriv = DV_W'(trunc_in);
        end
        if (deriv > MAX32)
        begin
            deriv_sat  = 32'sh7FFFFFFF;
            deriv_flag = 1'b1;
        end
        else if (deriv < MIN32)
        begin
            deriv_sat  = 32'sh80000000;
            deriv_flag = 1'b1;
        end
        else
        begin
            deriv_sat  = 32'(deriv);
            deriv_flag = 1'b0;
        end

        quot     = quot_prod_in[nau_pkg::DIV100_PROD_W-1:nau_pkg::DIV100_SHIFT];
        sat_next = 1'b0;
        if (ctl_in.opcode == nau_pkg::OP_ACTIVATE)
        begin
            case (ctl_in.kind)
                nau_pkg::KIND_SIGMOID: simple_next = '0;
                nau_pkg::KIND_TANH:    simple_next = '0;
                nau_pkg::KIND_RELU:    simple_next = (value_in > 0) ? value_in : '0;
                nau_pkg::KIND_LEAKY:   simple_next = (value_in > 0) ? value_in : -32'(quot);
                nau_pkg::KIND_LINEAR:  simple_next = value_in;
                default:               simple_next = value_in;
            endcase
        end
        else
        begin
            case (ctl_in.kind)
                nau_pkg::KIND_SIGMOID,
                nau_pkg::KIND_TANH:
                begin
                    simple_next = deriv_sat;
                    sat_next    = deriv_flag;
                end
                nau_pkg::KIND_RELU:   simple_next = (value_in > 0) ? ONE : '0;
                nau_pkg::KIND_LEAKY:  simple_next = (value_in > 0) ? ONE : LEAK_SLOPE;
                nau_pkg::KIND_LINEAR: simple_next = ONE;
                default:              simple_next = value_in;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        simple_reg <= simple_next;
        sat_reg    <= sat_next;
        lo_reg     <= lo_in;
        interp_reg <= interp_next;
    end

    always_comb
    begin
        tval     = lo_reg + TW'(interp_reg >> FRACTION_BITS);
        sig_sum  = SUM_W'(ONE) + SUM_W'(tval) + SUM_W'(1);
        sig_half = TW'(sig_sum >> 1);
        sig_res  = ctl_reg.neg ? (ONE - 32'(sig_half)) : 32'(sig_half);
        tanh_res = ctl_reg.neg ? -32'(tval) : 32'(tval);
        final_value = simple_reg;
        if (ctl_reg.opcode == nau_pkg::OP_ACTIVATE)
        begin
            case (ctl_reg.kind)
                nau_pkg::KIND_SIGMOID: final_value = sig_res;
                nau_pkg::KIND_TANH:    final_value = tanh_res;
                default:               final_value = simple_reg;
            endcase
        end
        res.valid     = ctl_reg.valid;
        res.value     = final_value;
        res.saturated = sat_reg;
    end

endmodule

// ----- hdl/nau_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activation unit result queue
// Holds finished results until the result channel takes them. The depth is a
// power of two, and the top level never lets it overflow.
// ----------------------------------------------------------------------------
module nau_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nau_pkg::res_t        wr,
    nau_result_if.source         result
);

    localparam int PTR_W = $clog2(nau_pkg::QUEUE_DEPTH);

    logic signed [nau_pkg::DATA_W-1:0] entry_value_reg [nau_pkg::QUEUE_DEPTH];
    logic                              entry_sat_reg [nau_pkg::QUEUE_DEPTH];
    logic [PTR_W:0]                    wr_ptr_reg;
    logic [PTR_W:0]                    wr_ptr_next;
    logic [PTR_W:0]                    rd_ptr_reg;
    logic [PTR_W:0]                    rd_ptr_next;
    logic                              empty;
    logic                              take;

    always_comb
    begin
        empty       = wr_ptr_reg == rd_ptr_reg;
        take        = !empty && result.ready;
        wr_ptr_next = wr.valid ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = take ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            entry_value_reg[wr_ptr_reg[PTR_W-1:0]] <= wr.value;
            entry_sat_reg[wr_ptr_reg[PTR_W-1:0]]   <= wr.saturated;
        end
    end

    assign result.valid        = !empty;
    assign result.result_value = entry_value_reg[rd_ptr_reg[PTR_W-1:0]];
    assign result.saturated    = entry_sat_reg[rd_ptr_reg[PTR_W-1:0]];

endmodule

// ----- hdl/neural_activation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neural network activation unit
// Sigmoid, tanh, relu, leaky relu and linear activations and derivatives on
// signed fixed-point values, sigmoid and tanh by interpolated table lookup.
// ----------------------------------------------------------------------------
//  Channel   Direction   Payload
//  item      in          opcode, function_kind, operand_value
//  result    out         result_value, saturated
//
//  One item is accepted per cycle while item.ready is high; a result goes
//  through the three register stages of the datapath into the result queue.
//  The datapath never stalls. A credit counter admits an item only while the
//  eight-entry result queue has room for everything in flight, so item.ready
//  drops only after eight results are waiting or moving.
//  Reset clears the stage valid bits, the queue pointers and the counter.
// ----------------------------------------------------------------------------
module neural_activation_unit #(
    parameter int TABLE_ENTRIES = nau_pkg::TABLE_ENTRIES_DEF,
    parameter int FRACTION_BITS = nau_pkg::FRACTION_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    nau_item_if.sink      item,
    nau_result_if.source  result
);

    localparam int ENT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int MAG_W   = FRACTION_BITS + 6;
    localparam int POS_W   = MAG_W + ENT_W - 3;
    localparam int TW      = FRACTION_BITS + 1;
    localparam int TRUNC_W = 64 - FRACTION_BITS;
    localparam int OCC_W   = $clog2(nau_pkg::QUEUE_DEPTH + 1);

    logic                                accept;
    logic                                drain;
    logic [OCC_W-1:0]                    occ_reg;
    logic [OCC_W-1:0]                    occ_next;

    nau_pkg::ctl_t                       s1_ctl;
    logic signed [nau_pkg::DATA_W-1:0]   s1_value;
    logic [POS_W-1:0]                    s1_pos;
    logic signed [63:0]                  s1_prod;

    nau_pkg::ctl_t                       s2_ctl;
    logic signed [nau_pkg::DATA_W-1:0]   s2_value;
    logic [TW-1:0]                       s2_lo;
    logic [TW-1:0]                       s2_hi;
    logic [FRACTION_BITS-1:0]            s2_frac;
    logic signed [TRUNC_W-1:0]           s2_trunc;
    logic [nau_pkg::DIV100_PROD_W-1:0]   s2_quot_prod;

    nau_pkg::res_t                       fin_res;

    assign item.ready = occ_reg < OCC_W'(nau_pkg::QUEUE_DEPTH);
    assign accept     = item.valid && item.ready;
    assign drain      = result.valid && result.ready;

    always_comb
    begin
        case ({accept, drain})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    nau_prep #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .opcode        (item.opcode),
        .function_kind (item.function_kind),
        .operand_value (item.operand_value),
        .ctl           (s1_ctl),
        .value         (s1_value),
        .pos           (s1_pos),
        .prod          (s1_prod)
    );

    nau_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (s1_ctl),
        .value_in  (s1_value),
        .pos_in    (s1_pos),
        .prod_in   (s1_prod),
        .ctl       (s2_ctl),
        .value     (s2_value),
        .lo        (s2_lo),
        .hi        (s2_hi),
        .frac      (s2_frac),
        .trunc     (s2_trunc),
        .quot_prod (s2_quot_prod)
    );

    nau_finish #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (s2_ctl),
        .value_in     (s2_value),
        .lo_in        (s2_lo),
        .hi_in        (s2_hi),
        .frac_in      (s2_frac),
        .trunc_in     (s2_trunc),
        .quot_prod_in (s2_quot_prod),
        .res          (fin_res)
    );

    nau_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (fin_res),
        .result (result)
    );

    // Every transfer in reaches the queue through the three register stages.
    a_fixed_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##3 fin_res.valid
    ) else $error("accepted item did not reach the result queue in three cycles");

    // A full credit count means at least one result waits in the queue.
    a_full_has_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid
    ) else $error("input blocked while no result is waiting");

    // A result leaving the datapath was counted when its item came in.
    a_result_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        fin_res.valid |-> (occ_reg != '0)
    ) else $error("result written with no item in flight");

endmodule
